### rtl/spq_pkg.sv
// shared types, constants and codes for the sorted priority queue
package spq_pkg;

    // store geometry
    localparam int CAPACITY = 16;
    localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // field widths
    localparam int DATA_W = 32;
    localparam int PRIO_W = 8;
    localparam int STAT_W = 2;
    localparam int OCC_W  = 5;

    // data word returned on an empty dequeue
    localparam logic signed [DATA_W-1:0] DATA_UNDERFLOW = -32'sd1;

    // command codes
    typedef enum logic [0:0] {
        CMD_ENQ = 1'b0,
        CMD_DEQ = 1'b1
    } spq_cmd_t;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_UNDERFLOW = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;

    // input transaction
    typedef struct packed {
        spq_cmd_t                  cmd;
        logic signed [DATA_W-1:0]  data_in;
        logic        [PRIO_W-1:0]  prio_in;
    } spq_in_t;

    // result transaction
    typedef struct packed {
        logic        [STAT_W-1:0]  status;
        logic signed [DATA_W-1:0]  data_out;
        logic        [OCC_W-1:0]   occupancy;
    } spq_out_t;

    // one stored entry
    typedef struct packed {
        logic [PRIO_W-1:0] prio;
        logic [DATA_W-1:0] data;
    } spq_entry_t;

endpackage

### rtl/spq_ram.sv
// generic single write, single read ram with registered read data
module spq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                              aclk,
    input  logic                              we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                  wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/sorted_priority_queue.sv
// sorted priority queue: ram store kept in descending priority, one compare unit
// flow: an enqueue walks from the tail, moving lower-priority entries back one place until
//   an entry of equal or higher priority stops the scan, then writes the new entry; a dequeue
//   takes the head and moves the rest forward; a full enqueue or empty dequeue goes straight to the result
// throughput: one transaction at a time, set by the read-compare-write walk over the ram
// reset: synchronous active-low aresetn empties the queue; ram contents are not cleared
module sorted_priority_queue
    import spq_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  spq_in_t  s_item,
    output logic     m_valid,
    input  logic     m_ready,
    output spq_out_t m_item
);

    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_ENQ_RD  = 7'b0000010,
        S_ENQ_CMP = 7'b0000100,
        S_ENQ_PUT = 7'b0001000,
        S_DEQ_RD  = 7'b0010000,
        S_DEQ_WR  = 7'b0100000,
        S_DONE    = 7'b1000000
    } state_t;

    state_t                   state_reg, state_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [ADDR_W-1:0]        idx_reg, idx_next;
    logic [ADDR_W-1:0]        put_addr_reg, put_addr_next;
    spq_in_t                  item_reg, item_next;
    logic [STAT_W-1:0]        res_status_reg, res_status_next;
    logic signed [DATA_W-1:0] res_data_reg, res_data_next;
    logic                     m_valid_reg, m_valid_next;
    spq_out_t                 m_item_reg, m_item_next;

    logic                     ram_we;
    logic [ADDR_W-1:0]        ram_waddr;
    spq_entry_t               ram_wdata;
    spq_entry_t               ram_rdata;

    logic                     is_full;
    logic                     is_empty;
    logic                     at_tail;

    // entry store
    spq_ram #(
        .WIDTH ($bits(spq_entry_t)),
        .DEPTH (CAPACITY)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    assign is_full  = (count_reg == CNT_W'(CAPACITY));
    assign is_empty = (count_reg == '0);
    assign at_tail  = (CNT_W'(idx_reg) == (count_reg - CNT_W'(1)));

    // sequencer and shared compare
    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        put_addr_next   = put_addr_reg;
        item_next       = item_reg;
        res_status_next = res_status_reg;
        res_data_next   = res_data_reg;
        m_item_next     = m_item_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        ram_we          = 1'b0;
        ram_waddr       = idx_reg;
        ram_wdata       = ram_rdata;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    item_next = s_item;
                    if (s_item.cmd == CMD_ENQ) begin
                        if (is_full) begin
                            res_status_next = ST_FULL;
                            res_data_next   = '0;
                            state_next      = S_DONE;
                        end else if (is_empty) begin
                            put_addr_next = '0;
                            state_next    = S_ENQ_PUT;
                        end else begin
                            idx_next   = ADDR_W'(count_reg - CNT_W'(1));
                            state_next = S_ENQ_RD;
                        end
                    end else begin
                        if (is_empty) begin
                            res_status_next = ST_UNDERFLOW;
                            res_data_next   = DATA_UNDERFLOW;
                            state_next      = S_DONE;
                        end else begin
                            idx_next   = '0;
                            state_next = S_DEQ_RD;
                        end
                    end
                end
            end
            S_ENQ_RD: begin
                state_next = S_ENQ_CMP;
            end
            S_ENQ_CMP: begin
                // stop behind an entry of equal or higher priority, else move it back
                if (ram_rdata.prio >= item_reg.prio_in) begin
                    put_addr_next = idx_reg + ADDR_W'(1);
                    state_next    = S_ENQ_PUT;
                end else begin
                    ram_we    = 1'b1;
                    ram_waddr = idx_reg + ADDR_W'(1);
                    if (idx_reg == '0) begin
                        put_addr_next = '0;
                        state_next    = S_ENQ_PUT;
                    end else begin
                        idx_next   = idx_reg - ADDR_W'(1);
                        state_next = S_ENQ_RD;
                    end
                end
            end
            S_ENQ_PUT: begin
                ram_we          = 1'b1;
                ram_waddr       = put_addr_reg;
                ram_wdata.prio  = item_reg.prio_in;
                ram_wdata.data  = item_reg.data_in;
                count_next      = count_reg + CNT_W'(1);
                res_status_next = ST_OK;
                res_data_next   = '0;
                state_next      = S_DONE;
            end
            S_DEQ_RD: begin
                state_next = S_DEQ_WR;
            end
            S_DEQ_WR: begin
                // head goes out, the rest moves one place forward
                if (idx_reg == '0) begin
                    res_data_next = ram_rdata.data;
                end else begin
                    ram_we    = 1'b1;
                    ram_waddr = idx_reg - ADDR_W'(1);
                end
                if (at_tail) begin
                    count_next      = count_reg - CNT_W'(1);
                    res_status_next = ST_OK;
                    state_next      = S_DONE;
                end else begin
                    idx_next   = idx_reg + ADDR_W'(1);
                    state_next = S_DEQ_RD;
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_item_next.status    = res_status_reg;
                    m_item_next.data_out  = res_data_reg;
                    m_item_next.occupancy = OCC_W'(count_reg);
                    m_valid_next          = 1'b1;
                    state_next            = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        idx_reg        <= idx_next;
        put_addr_reg   <= put_addr_next;
        item_reg       <= item_next;
        res_status_reg <= res_status_next;
        res_data_reg   <= res_data_next;
        m_item_reg     <= m_item_next;
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

`ifndef ASSERT_OFF
    // held entries never exceed the store size
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    // store is only written while a transaction is in progress
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE || state_reg == S_DONE) |-> !ram_we)
        else $error("store written outside a transaction");

    // writes never land beyond one past the held entries
    assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (CNT_W'(ram_waddr) <= count_reg))
        else $error("store write beyond held entries");

    // a dropped enqueue reports a full store
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_item.status == ST_FULL) |-> (m_item.occupancy == OCC_W'(CAPACITY)))
        else $error("full status with store not full");

    // an underflow reports an empty store and the all-ones word
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_item.status == ST_UNDERFLOW)
            |-> (m_item.occupancy == '0 && m_item.data_out == DATA_UNDERFLOW))
        else $error("underflow result malformed");
`endif

endmodule
